>>> rtl/core/cpge_pkg.sv
`timescale 1ns / 1ps
package cpge_pkg;

  localparam int DEF_MAX_SAMPLES = 64;
  localparam int DEF_MAX_DIM     = 4;
  localparam int DEF_FRAC_BITS   = 16;

  localparam int NTERMS = 4;
  localparam int NRED   = 2;

  localparam logic [2:0] DIM_RESET = 3'd3;

  typedef enum logic [2:0] {
    REQ_U_CURVE = 3'd0,
    REQ_V_CURVE = 3'd1,
    REQ_CORNER  = 3'd2,
    REQ_U_BASIS = 3'd3,
    REQ_V_BASIS = 3'd4,
    REQ_EVAL    = 3'd5
  } req_t;

  typedef enum logic {
    CFG_DIMENSION = 1'b0,
    CFG_REDUCED   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASIS,
    ST_RUN,
    ST_OUT
  } state_t;

endpackage

>>> rtl/core/coons_patch_grid_eval.sv
`timescale 1ns / 1ps
// Coons patch evaluator. Load transfers write one table word each and are taken
// back to back. An evaluate transfer occupies the block until its result is
// registered: it first fetches the eight basis words, then works through the
// coordinates in turn with nk terms each, where nk is 4 in full mode and 2 in
// reduced mode, and last registers the result. Its length is set by the one
// shared 32x32 multiplier and the corner table, which delivers one word per
// cycle. A finished result waits in the output register while the next transfer
// is accepted. Table contents are undefined until written; there is no clearing
// pass after reset.
module coons_patch_grid_eval #(
  parameter int MAX_SAMPLES = cpge_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_DIM     = cpge_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS   = cpge_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cpge_pkg::cfg_idx_t cfg_index,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [5:0]         in_u_index,
  input  logic [5:0]         in_v_index,
  input  logic [1:0]         in_slot,
  input  logic [1:0]         in_corner_col,
  input  logic [1:0]         in_coord,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_point_u,
  output logic [5:0]         out_point_v,
  output logic signed [31:0] out_coord0,
  output logic signed [31:0] out_coord1,
  output logic signed [31:0] out_coord2,
  output logic signed [31:0] out_coord3,
  output logic               out_overflow
);
  import cpge_pkg::*;

  localparam int CDEPTH = MAX_SAMPLES * NTERMS * MAX_DIM;
  localparam int KDEPTH = NTERMS * NTERMS * MAX_DIM;
  localparam int BDEPTH = MAX_SAMPLES * NTERMS;
  localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int KAW = $clog2(KDEPTH);
  localparam int BAW = $clog2(BDEPTH);

  function automatic logic signed [63:0] fx_mul(logic signed [31:0] a,
                                                logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] x);
    if (x[63:31] == {33{x[63]}}) return x[31:0];
    return x[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic is_sat(logic signed [63:0] x);
    return x[63:31] != {33{x[63]}};
  endfunction

  logic signed [31:0] ucv_mem [0:CDEPTH-1];
  logic signed [31:0] vcv_mem [0:CDEPTH-1];
  logic signed [31:0] cor_mem [0:KDEPTH-1];
  logic signed [31:0] ubs_mem [0:BDEPTH-1];
  logic signed [31:0] vbs_mem [0:BDEPTH-1];
  logic signed [31:0] ucv_q, vcv_q, cor_q, ubs_q, vbs_q;

  state_t st_r, st_nxt;
  logic [2:0]  dim_r;
  logic        red_r;
  logic [2:0]  dim_eff_r;
  logic        red_eval_r;
  logic [5:0]  u_r, v_r;
  logic [2:0]  b_r;
  logic [3:0]  ph_r;
  logic [1:0]  k_r, l_r;
  logic signed [31:0] hv_r [0:3];
  logic signed [31:0] hu_r [0:3];
  logic signed [63:0] t_r, prod_r, acc_r, acc_sum;
  logic signed [31:0] c_r, a_r;
  logic signed [31:0] crd_r [0:3];
  logic        ovf_r;
  logic        out_valid_r;
  logic [5:0]  out_u_r, out_v_r;
  logic signed [31:0] out_crd_r [0:3];
  logic        out_ovf_r;

  logic        in_xfer, eval_ok, last_k, last_l, out_free;
  logic [3:0]  nk4;
  logic [1:0]  km1;
  logic [CAW-1:0] ucv_wa, vcv_wa, ucv_ra, vcv_ra;
  logic [KAW-1:0] cor_wa, cor_ra;
  logic [BAW-1:0] ubs_wa, vbs_wa, ubs_ra, vbs_ra;
  logic signed [31:0] mul_a, mul_b;
  logic [1:0]  hsel_m, hsel_k;

  assign cfg_ready = 1'b1;
  assign in_stall  = (st_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign eval_ok   = (int'(in_u_index) < MAX_SAMPLES) && (int'(in_v_index) < MAX_SAMPLES);
  assign out_free  = !out_valid_r || !out_stall;

  assign nk4    = red_eval_r ? 4'(NRED) : 4'(NTERMS);
  assign km1    = 2'(nk4 - 4'd1);
  assign last_k = (k_r == km1);
  assign last_l = ({1'b0, l_r} == 3'(dim_eff_r - 3'd1));

  assign ucv_wa = CAW'((int'(in_u_index) * NTERMS + int'(in_slot)) * MAX_DIM + int'(in_coord));
  assign vcv_wa = CAW'((int'(in_v_index) * NTERMS + int'(in_slot)) * MAX_DIM + int'(in_coord));
  assign cor_wa = KAW'((int'(in_slot) * NTERMS + int'(in_corner_col)) * MAX_DIM
                       + int'(in_coord));
  assign ubs_wa = BAW'(int'(in_u_index) * NTERMS + int'(in_slot));
  assign vbs_wa = BAW'(int'(in_v_index) * NTERMS + int'(in_slot));

  assign ucv_ra = CAW'((int'(u_r) * NTERMS + int'(k_r)) * MAX_DIM + int'(l_r));
  assign vcv_ra = CAW'((int'(v_r) * NTERMS + int'(k_r)) * MAX_DIM + int'(l_r));
  assign cor_ra = KAW'((int'(k_r) * NTERMS + int'(ph_r[1:0])) * MAX_DIM + int'(l_r));
  assign ubs_ra = BAW'(int'(u_r) * NTERMS + int'(b_r[1:0]));
  assign vbs_ra = BAW'(int'(v_r) * NTERMS + int'(b_r[1:0]));

  always_ff @(posedge clk) begin
    if (in_xfer && in_req_type == REQ_U_CURVE && int'(in_u_index) < MAX_SAMPLES
        && int'(in_coord) < MAX_DIM) begin
      ucv_mem[ucv_wa] <= in_value;
    end
    if (in_xfer && in_req_type == REQ_V_CURVE && int'(in_v_index) < MAX_SAMPLES
        && int'(in_coord) < MAX_DIM) begin
      vcv_mem[vcv_wa] <= in_value;
    end
    if (in_xfer && in_req_type == REQ_CORNER && int'(in_coord) < MAX_DIM) begin
      cor_mem[cor_wa] <= in_value;
    end
    if (in_xfer && in_req_type == REQ_U_BASIS && int'(in_u_index) < MAX_SAMPLES) begin
      ubs_mem[ubs_wa] <= in_value;
    end
    if (in_xfer && in_req_type == REQ_V_BASIS && int'(in_v_index) < MAX_SAMPLES) begin
      vbs_mem[vbs_wa] <= in_value;
    end
    ucv_q <= ucv_mem[ucv_ra];
    vcv_q <= vcv_mem[vcv_ra];
    cor_q <= cor_mem[cor_ra];
    ubs_q <= ubs_mem[ubs_ra];
    vbs_q <= vbs_mem[vbs_ra];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_xfer && in_req_type == REQ_EVAL && eval_ok) st_nxt = ST_BASIS;
      end
      ST_BASIS: begin
        if (b_r == 3'd4) st_nxt = (dim_eff_r == 3'd0) ? ST_OUT : ST_RUN;
      end
      ST_RUN: begin
        if (ph_r == nk4 + 4'd4 && last_k && last_l) st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign hsel_m = red_eval_r ? {ph_r[0] ^ 1'b1, 1'b0} : 2'(ph_r - 4'd1);
  assign hsel_k = red_eval_r ? {k_r[0], 1'b0} : k_r;

  always_comb begin
    mul_a = cor_q;
    mul_b = hv_r[hsel_m];
    if (ph_r == nk4 + 4'd1) begin
      mul_a = c_r;
      mul_b = hv_r[hsel_k];
    end else if (ph_r == nk4 + 4'd3) begin
      mul_a = a_r;
      mul_b = hu_r[hsel_k];
    end
  end

  assign acc_sum = acc_r + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r       <= DIM_RESET;
      red_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DIMENSION: dim_r <= cfg_data;
          CFG_REDUCED:   red_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (st_r == ST_OUT && out_free) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_xfer) begin
      u_r        <= in_u_index;
      v_r        <= in_v_index;
      b_r        <= 3'd0;
      ph_r       <= 4'd0;
      k_r        <= 2'd0;
      l_r        <= 2'd0;
      acc_r      <= '0;
      ovf_r      <= 1'b0;
      red_eval_r <= red_r;
      dim_eff_r  <= (int'(dim_r) > MAX_DIM) ? 3'(MAX_DIM) : dim_r;
      for (int i = 0; i < 4; i++) crd_r[i] <= '0;
    end
    if (st_r == ST_BASIS) begin
      b_r <= b_r + 3'd1;
      if (b_r != 3'd0) begin
        hv_r[2'(b_r - 3'd1)] <= vbs_q;
        hu_r[2'(b_r - 3'd1)] <= ubs_q;
      end
    end
    if (st_r == ST_RUN) begin
      prod_r <= fx_mul(mul_a, mul_b);
      ph_r   <= ph_r + 4'd1;
      if (ph_r == 4'd1) begin
        t_r <= 64'(vcv_q);
        c_r <= ucv_q;
      end else if (ph_r >= 4'd2 && ph_r <= nk4 + 4'd1) begin
        t_r <= t_r - prod_r;
      end
      if (ph_r == nk4 + 4'd2) begin
        acc_r <= acc_sum;
        a_r   <= sat32(t_r);
        if (is_sat(t_r)) ovf_r <= 1'b1;
      end
      if (ph_r == nk4 + 4'd4) begin
        ph_r <= 4'd0;
        if (last_k) begin
          k_r          <= 2'd0;
          l_r          <= l_r + 2'd1;
          acc_r        <= '0;
          crd_r[l_r]   <= sat32(acc_sum);
          if (is_sat(acc_sum)) ovf_r <= 1'b1;
        end else begin
          k_r   <= k_r + 2'd1;
          acc_r <= acc_sum;
        end
      end
    end
    if (st_r == ST_OUT && out_free) begin
      out_u_r   <= u_r;
      out_v_r   <= v_r;
      out_ovf_r <= ovf_r;
      for (int i = 0; i < 4; i++) out_crd_r[i] <= crd_r[i];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_point_u  = out_u_r;
  assign out_point_v  = out_v_r;
  assign out_coord0   = out_crd_r[0];
  assign out_coord1   = out_crd_r[1];
  assign out_coord2   = out_crd_r[2];
  assign out_coord3   = out_crd_r[3];
  assign out_overflow = out_ovf_r;

endmodule

>>> rtl/core/cpge_chk.sv
`timescale 1ns / 1ps
module cpge_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         in_req_type,
  input logic               out_valid,
  input logic               out_stall
);
  import cpge_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("Configuration write was not taken.");

  a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_req_type != REQ_EVAL) |=> !in_stall)
    else $error("Input stalled after a load transfer.");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared without an evaluation in progress.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("Stalled result was dropped.");

endmodule

bind coons_patch_grid_eval cpge_chk u_cpge_chk (.*);
